@@ rtl/xpbd_pkg.sv @@
// Shared widths and constants for the XPBD distance constraint pipeline.
package xpbd_pkg;
  localparam int COORD_W  = 32;
  localparam int MASS_W   = 31;
  localparam int FIELD_IDX_W = 24;
  localparam int GEO_W    = 8;
  localparam int DIFF_W   = 33;
  localparam int RAD_W    = 66;
  localparam int LEN_W    = 33;
  localparam int DIR_W    = 31;
  localparam int RCP_W    = 33;
  localparam int MSUM_W   = 32;
  localparam int DEN_W    = 35;
  localparam int LMAG_W   = 34;
  localparam int LAM_W    = LMAG_W + 16;
  localparam int WU_W     = 2 * DIR_W;
  localparam int PART_W   = 25;
  localparam int PP_W     = PART_W + DIR_W;
  localparam int HALF_W   = PP_W + DIR_W + 1;
  localparam int FULL_W   = HALF_W + PART_W;
  localparam int Q_SHIFT  = 60;
  localparam int Q_W      = FULL_W - Q_SHIFT;
  localparam int CORR_W   = 32;
  // 1.0 in Q16.16 divided into Q16.16 gives 2^32
  localparam logic [RCP_W-1:0] RCP_ONE = {1'b1, {(RCP_W-1){1'b0}}};
  localparam logic [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};
endpackage

@@ rtl/xpbd_cons_if.sv @@
// Constraint input channel.
interface xpbd_cons_if #(parameter int POINT_INDEX_BITS = 24);
  logic valid;
  logic ready;
  logic signed [xpbd_pkg::COORD_W-1:0] pos_a_x, pos_a_y, pos_a_z;
  logic signed [xpbd_pkg::COORD_W-1:0] pos_b_x, pos_b_y, pos_b_z;
  logic [xpbd_pkg::MASS_W-1:0] mass_a, mass_b, rest_length;
  logic [POINT_INDEX_BITS-1:0] point_a_index, point_b_index;
  logic [xpbd_pkg::GEO_W-1:0] geometry_index;
  modport source(output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                 mass_a, mass_b, rest_length, point_a_index, point_b_index,
                 geometry_index, input ready);
  modport sink(input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
               mass_a, mass_b, rest_length, point_a_index, point_b_index,
               geometry_index, output ready);
endinterface

@@ rtl/xpbd_corr_if.sv @@
// Correction result channel.
interface xpbd_corr_if #(parameter int POINT_INDEX_BITS = 24);
  logic valid;
  logic ready;
  logic signed [xpbd_pkg::CORR_W-1:0] corr_a_x, corr_a_y, corr_a_z;
  logic signed [xpbd_pkg::CORR_W-1:0] corr_b_x, corr_b_y, corr_b_z;
  logic [xpbd_pkg::FIELD_IDX_W-1:0] out_point_a, out_point_b;
  logic [xpbd_pkg::GEO_W-1:0] out_geometry;
  modport source(output valid, corr_a_x, corr_a_y, corr_a_z, corr_b_x, corr_b_y, corr_b_z,
                 out_point_a, out_point_b, out_geometry, input ready);
  modport sink(input valid, corr_a_x, corr_a_y, corr_a_z, corr_b_x, corr_b_y, corr_b_z,
               out_point_a, out_point_b, out_geometry, output ready);
endinterface

@@ rtl/xpbd_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, optional tail delay.
module xpbd_div_pipe #(
  parameter int DEN_W = 35,
  parameter int QW    = 50,
  parameter int LAT   = 50
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] r0,
  input  logic [QW-1:0]    low,
  input  logic [DEN_W-1:0] den,
  output logic [QW-1:0]    quo
);
  // r0 must be below den
  logic [DEN_W-1:0] rem [QW+1];
  logic [QW-1:0]    lo  [QW+1];
  logic [DEN_W-1:0] dv  [QW+1];
  logic [QW-1:0]    q   [QW+1];
  logic [QW-1:0]    pd  [LAT-QW+1];

  assign rem[0] = r0;
  assign lo[0]  = low;
  assign dv[0]  = den;
  assign q[0]   = '0;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DEN_W:0] cur;
    logic [DEN_W:0] diff;
    logic           ge;
    always_comb begin
      cur  = {rem[j], lo[j][QW-1]};
      diff = cur - {1'b0, dv[j]};
      ge   = cur >= {1'b0, dv[j]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        lo[j+1]  <= {lo[j][QW-2:0], 1'b0};
        dv[j+1]  <= dv[j];
        q[j+1]   <= {q[j][QW-2:0], ge};
      end
    end
  end

  assign pd[0] = q[QW];
  for (genvar k = 0; k < LAT - QW; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        pd[k+1] <= pd[k];
      end
    end
  end
  assign quo = pd[LAT-QW];
endmodule

@@ rtl/xpbd_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage.
module xpbd_sqrt_pipe #(
  parameter int RAD_W = 66,
  localparam int ROOT_W = (RAD_W + 1) / 2
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);
  localparam int RW = ROOT_W + 3;
  localparam int VW = 2 * ROOT_W;

  logic [RW-1:0]     rem [ROOT_W+1];
  logic [ROOT_W-1:0] rt  [ROOT_W+1];
  logic [VW-1:0]     v   [ROOT_W+1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign v[0]   = VW'(rad);

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;
    always_comb begin
      cur   = {rem[j][RW-3:0], v[j][VW-1:VW-2]};
      trial = {1'b0, rt[j], 2'b01};
      ge    = cur >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? cur - trial : cur;
        rt[j+1]  <= {rt[j][ROOT_W-2:0], ge};
        v[j+1]   <= {v[j][VW-3:0], 2'b00};
      end
    end
  end
  assign root = rt[ROOT_W];
endmodule

@@ rtl/xpbd_distance_constraint.sv @@
// Top level: XPBD distance constraint correction pipeline.
//
//  channel | role   | transfer when        | content
//  cons    | sink   | valid && ready       | two points, masses, rest length, indices
//  corr    | source | valid && ready       | six saturated corrections, indices
//  cfg     | write  | cfg_we high          | compliance over substep time squared
//
// One item per cycle while the second output buffer entry is empty. Stages:
// square root 33, reciprocal bank 33, lambda divider 50, plus stage 1,
// stages 2 and 3, prep, D and F1..F4. Every stage advances together; a
// two-entry output buffer holds results, and cons.ready drops while the second entry is full.
// Reset clears the valids (buffer entries included) and the compliance register.
module xpbd_distance_constraint #(
  parameter int POINT_INDEX_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [xpbd_pkg::MASS_W-1:0] cfg_wdata,
  xpbd_cons_if.sink                   cons,
  xpbd_corr_if.source                 corr
);
  localparam int KEEP  = (POINT_INDEX_BITS < xpbd_pkg::FIELD_IDX_W) ?
                         POINT_INDEX_BITS : xpbd_pkg::FIELD_IDX_W;
  localparam int IDX_W = 2 * KEEP + xpbd_pkg::GEO_W;
  localparam int NST   = 3 + xpbd_pkg::LEN_W + 1 + xpbd_pkg::RCP_W + 1
                         + xpbd_pkg::LAM_W + 4;

  typedef struct packed {
    logic [2:0][xpbd_pkg::DIFF_W-1:0] mag;
    logic [2:0]                       dneg;
    logic [xpbd_pkg::MASS_W-1:0]      m0;
    logic [xpbd_pkg::MASS_W-1:0]      m1;
    logic [xpbd_pkg::MASS_W-1:0]      rest;
    logic [IDX_W-1:0]                 idx;
  } geo_side_t;

  typedef struct packed {
    logic [2:0]                  dneg;
    logic                        lneg;
    logic [xpbd_pkg::LMAG_W-1:0] lmag;
    logic                        wz;
    logic [IDX_W-1:0]            idx;
  } bank_a_side_t;

  typedef struct packed {
    logic [2:0][xpbd_pkg::DIR_W-1:0] dirm;
    logic [xpbd_pkg::DIR_W-1:0]      w0;
    logic [xpbd_pkg::DIR_W-1:0]      w1;
    logic                            lneg;
    logic [2:0]                      dneg;
    logic [IDX_W-1:0]                idx;
  } bank_b_side_t;

  typedef struct packed {
    logic [5:0][xpbd_pkg::CORR_W-1:0] c;
    logic [IDX_W-1:0]                 idx;
  } result_t;

  logic                        en;
  logic [NST-1:0]              vp;
  logic [xpbd_pkg::MASS_W-1:0] compliance;

  always_ff @(posedge clk) begin
    if (rst) begin
      compliance <= '0;
    end else if (cfg_we) begin
      compliance <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[NST-2:0], cons.valid};
    end
  end
  assign cons.ready = en;

  // stage 1: difference vector
  logic signed [xpbd_pkg::DIFF_W-1:0] dlt [3];
  logic [xpbd_pkg::COORD_W-1:0] pa [3];
  logic [xpbd_pkg::COORD_W-1:0] pb [3];
  geo_side_t s1, s2, s3;

  always_comb begin
    pa[0] = cons.pos_a_x; pa[1] = cons.pos_a_y; pa[2] = cons.pos_a_z;
    pb[0] = cons.pos_b_x; pb[1] = cons.pos_b_y; pb[2] = cons.pos_b_z;
    for (int i = 0; i < 3; i++) begin
      dlt[i] = {pb[i][xpbd_pkg::COORD_W-1], pb[i]} - {pa[i][xpbd_pkg::COORD_W-1], pa[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1.dneg[i] <= dlt[i][xpbd_pkg::DIFF_W-1];
        s1.mag[i]  <= dlt[i][xpbd_pkg::DIFF_W-1] ? -dlt[i] : dlt[i];
      end
      s1.m0   <= cons.mass_a;
      s1.m1   <= cons.mass_b;
      s1.rest <= cons.rest_length;
      s1.idx  <= {cons.point_a_index[KEEP-1:0], cons.point_b_index[KEEP-1:0],
                  cons.geometry_index};
    end
  end

  // stages 2 and 3: squared length
  logic [xpbd_pkg::RAD_W-1:0] sq [3];
  logic [xpbd_pkg::RAD_W-1:0] sumsq;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= s1.mag[i] * s1.mag[i];
      end
      s2    <= s1;
      sumsq <= sq[0] + sq[1] + sq[2];
      s3    <= s2;
    end
  end

  // square root
  logic [xpbd_pkg::LEN_W-1:0] root;
  geo_side_t sq_dl [xpbd_pkg::LEN_W];

  xpbd_sqrt_pipe #(.RAD_W(xpbd_pkg::RAD_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sumsq),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_dl[0] <= s3;
      for (int k = 1; k < xpbd_pkg::LEN_W; k++) begin
        sq_dl[k] <= sq_dl[k-1];
      end
    end
  end

  // prep stage: length error and mass sum
  geo_side_t                    ps;
  logic [xpbd_pkg::LEN_W-1:0]   p_len;
  logic [xpbd_pkg::MSUM_W-1:0]  p_msum;
  logic                         p_lneg;
  logic [xpbd_pkg::LMAG_W-1:0]  p_lmag;
  logic signed [xpbd_pkg::LMAG_W:0] ldiff;
  geo_side_t                    sq_out;

  assign sq_out = sq_dl[xpbd_pkg::LEN_W-1];
  assign ldiff  = {2'b00, root} - {4'b0000, sq_out.rest};

  always_ff @(posedge clk) begin
    if (en) begin
      ps     <= sq_out;
      p_len  <= root;
      p_msum <= {1'b0, sq_out.m0} + {1'b0, sq_out.m1};
      p_lneg <= ldiff[xpbd_pkg::LMAG_W];
      p_lmag <= ldiff[xpbd_pkg::LMAG_W] ? xpbd_pkg::LMAG_W'(-ldiff)
                                         : ldiff[xpbd_pkg::LMAG_W-1:0];
    end
  end

  // bank A: reciprocals, direction, mass weights
  logic [xpbd_pkg::RCP_W-1:0] rc0, rc1;
  logic [xpbd_pkg::DIR_W-1:0] dirm [3];
  logic [xpbd_pkg::DIR_W-1:0] w0, w1;
  logic [xpbd_pkg::MASS_W-1:0] rd0, rd1;
  logic [xpbd_pkg::LEN_W-1:0]  lden;
  logic [xpbd_pkg::MSUM_W-1:0] wden;

  assign rd0  = (ps.m0 == '0) ? xpbd_pkg::MASS_W'(1) : ps.m0;
  assign rd1  = (ps.m1 == '0) ? xpbd_pkg::MASS_W'(1) : ps.m1;
  assign lden = (p_len == '0) ? xpbd_pkg::LEN_W'(1) : p_len;
  assign wden = (p_msum == '0) ? xpbd_pkg::MSUM_W'(1) : p_msum;

  xpbd_div_pipe #(.DEN_W(xpbd_pkg::MASS_W), .QW(xpbd_pkg::RCP_W), .LAT(xpbd_pkg::RCP_W))
    u_rcp0 (.clk(clk), .en(en), .r0('0), .low(xpbd_pkg::RCP_ONE), .den(rd0), .quo(rc0));
  xpbd_div_pipe #(.DEN_W(xpbd_pkg::MASS_W), .QW(xpbd_pkg::RCP_W), .LAT(xpbd_pkg::RCP_W))
    u_rcp1 (.clk(clk), .en(en), .r0('0), .low(xpbd_pkg::RCP_ONE), .den(rd1), .quo(rc1));

  for (genvar i = 0; i < 3; i++) begin : g_dir
    xpbd_div_pipe #(.DEN_W(xpbd_pkg::LEN_W), .QW(xpbd_pkg::DIR_W), .LAT(xpbd_pkg::RCP_W))
      u_dir (
        .clk (clk),
        .en  (en),
        .r0  ({1'b0, ps.mag[i][xpbd_pkg::DIFF_W-1:1]}),
        .low ({ps.mag[i][0], {(xpbd_pkg::DIR_W-1){1'b0}}}),
        .den (lden),
        .quo (dirm[i])
      );
  end

  xpbd_div_pipe #(.DEN_W(xpbd_pkg::MSUM_W), .QW(xpbd_pkg::DIR_W), .LAT(xpbd_pkg::RCP_W))
    u_w0 (
      .clk (clk),
      .en  (en),
      .r0  ({2'b00, ps.m0[xpbd_pkg::MASS_W-1:1]}),
      .low ({ps.m0[0], {(xpbd_pkg::DIR_W-1){1'b0}}}),
      .den (wden),
      .quo (w0)
    );
  xpbd_div_pipe #(.DEN_W(xpbd_pkg::MSUM_W), .QW(xpbd_pkg::DIR_W), .LAT(xpbd_pkg::RCP_W))
    u_w1 (
      .clk (clk),
      .en  (en),
      .r0  ({2'b00, ps.m1[xpbd_pkg::MASS_W-1:1]}),
      .low ({ps.m1[0], {(xpbd_pkg::DIR_W-1){1'b0}}}),
      .den (wden),
      .quo (w1)
    );

  bank_a_side_t a_in;
  bank_a_side_t a_dl [xpbd_pkg::RCP_W];

  always_comb begin
    a_in.dneg = ps.dneg;
    a_in.lneg = p_lneg;
    a_in.lmag = p_lmag;
    a_in.wz   = p_msum == '0;
    a_in.idx  = ps.idx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dl[0] <= a_in;
      for (int k = 1; k < xpbd_pkg::RCP_W; k++) begin
        a_dl[k] <= a_dl[k-1];
      end
    end
  end

  // stage D: denominator
  bank_a_side_t              a_out;
  bank_b_side_t              d_side;
  logic [xpbd_pkg::DEN_W-1:0]  d_denom;
  logic [xpbd_pkg::LMAG_W-1:0] d_lmag;

  assign a_out = a_dl[xpbd_pkg::RCP_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_denom <= xpbd_pkg::DEN_W'(rc0) + xpbd_pkg::DEN_W'(rc1)
                 + xpbd_pkg::DEN_W'(compliance);
      d_lmag  <= a_out.lmag;
      for (int i = 0; i < 3; i++) begin
        d_side.dirm[i] <= dirm[i];
      end
      d_side.w0   <= a_out.wz ? '0 : w0;
      d_side.w1   <= a_out.wz ? '0 : w1;
      d_side.lneg <= a_out.lneg;
      d_side.dneg <= a_out.dneg;
      d_side.idx  <= a_out.idx;
    end
  end

  // bank B: lambda
  logic [xpbd_pkg::LAM_W-1:0] lam;
  bank_b_side_t b_dl [xpbd_pkg::LAM_W];

  xpbd_div_pipe #(.DEN_W(xpbd_pkg::DEN_W), .QW(xpbd_pkg::LAM_W), .LAT(xpbd_pkg::LAM_W))
    u_lam (
      .clk (clk),
      .en  (en),
      .r0  ('0),
      .low ({d_lmag, 16'h0000}),
      .den (d_denom),
      .quo (lam)
    );

  always_ff @(posedge clk) begin
    if (en) begin
      b_dl[0] <= d_side;
      for (int k = 1; k < xpbd_pkg::LAM_W; k++) begin
        b_dl[k] <= b_dl[k-1];
      end
    end
  end

  // F1..F4: lambda * weight * direction, split multiply
  bank_b_side_t                      b_out;
  logic [5:0][xpbd_pkg::WU_W-1:0]    f1_wu;
  logic [xpbd_pkg::LAM_W-1:0]        f1_lam;
  logic [5:0]                        f1_neg, f2_neg, f3_neg, f4_neg;
  logic [IDX_W-1:0]                  f1_idx, f2_idx, f3_idx, f4_idx;
  logic [5:0][3:0][xpbd_pkg::PP_W-1:0] f2_pp;
  logic [5:0][xpbd_pkg::HALF_W-1:0]  f3_lo, f3_hi;
  logic [5:0][xpbd_pkg::Q_W-1:0]     f4_q;
  logic [xpbd_pkg::FULL_W-1:0]       full [6];

  assign b_out = b_dl[xpbd_pkg::LAM_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f1_wu[i]    <= b_out.w0 * b_out.dirm[i];
        f1_wu[3+i]  <= b_out.w1 * b_out.dirm[i];
        f1_neg[i]   <= b_out.lneg ^ b_out.dneg[i];
        f1_neg[3+i] <= ~(b_out.lneg ^ b_out.dneg[i]);
      end
      f1_lam <= lam;
      f1_idx <= b_out.idx;

      for (int k = 0; k < 6; k++) begin
        f2_pp[k][0] <= f1_lam[xpbd_pkg::PART_W-1:0] * f1_wu[k][xpbd_pkg::DIR_W-1:0];
        f2_pp[k][1] <= f1_lam[xpbd_pkg::PART_W-1:0] * f1_wu[k][xpbd_pkg::WU_W-1:xpbd_pkg::DIR_W];
        f2_pp[k][2] <= f1_lam[xpbd_pkg::LAM_W-1:xpbd_pkg::PART_W] * f1_wu[k][xpbd_pkg::DIR_W-1:0];
        f2_pp[k][3] <= f1_lam[xpbd_pkg::LAM_W-1:xpbd_pkg::PART_W]
                       * f1_wu[k][xpbd_pkg::WU_W-1:xpbd_pkg::DIR_W];
      end
      f2_neg <= f1_neg;
      f2_idx <= f1_idx;

      for (int k = 0; k < 6; k++) begin
        f3_lo[k] <= xpbd_pkg::HALF_W'(f2_pp[k][0])
                    + (xpbd_pkg::HALF_W'(f2_pp[k][1]) << xpbd_pkg::DIR_W);
        f3_hi[k] <= xpbd_pkg::HALF_W'(f2_pp[k][2])
                    + (xpbd_pkg::HALF_W'(f2_pp[k][3]) << xpbd_pkg::DIR_W);
      end
      f3_neg <= f2_neg;
      f3_idx <= f2_idx;

      for (int k = 0; k < 6; k++) begin
        f4_q[k] <= full[k][xpbd_pkg::FULL_W-1:xpbd_pkg::Q_SHIFT];
      end
      f4_neg <= f3_neg;
      f4_idx <= f3_idx;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      full[k] = xpbd_pkg::FULL_W'(f3_lo[k])
                + (xpbd_pkg::FULL_W'(f3_hi[k]) << xpbd_pkg::PART_W);
    end
  end

  // saturation
  result_t res;
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (f4_neg[k]) begin
        res.c[k] = (f4_q[k] >= xpbd_pkg::Q_W'(xpbd_pkg::CORR_MIN)) ? xpbd_pkg::CORR_MIN
                   : -f4_q[k][xpbd_pkg::CORR_W-1:0];
      end else begin
        res.c[k] = (f4_q[k] > xpbd_pkg::Q_W'(xpbd_pkg::CORR_MAX)) ? xpbd_pkg::CORR_MAX
                   : f4_q[k][xpbd_pkg::CORR_W-1:0];
      end
    end
    res.idx = f4_idx;
  end

  // output buffer
  logic    bin_v;
  logic    main_v, skid_v;
  result_t main_d, skid_d;

  assign bin_v = vp[NST-1] & en;
  assign en    = ~skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (corr.ready || !main_v) begin
      if (skid_v) begin
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        main_v <= bin_v;
      end
    end else if (bin_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (corr.ready || !main_v) begin
      if (skid_v) begin
        main_d <= skid_d;
      end else if (bin_v) begin
        main_d <= res;
      end
    end else if (bin_v) begin
      skid_d <= res;
    end
  end

  assign corr.valid        = main_v;
  assign corr.corr_a_x     = main_d.c[0];
  assign corr.corr_a_y     = main_d.c[1];
  assign corr.corr_a_z     = main_d.c[2];
  assign corr.corr_b_x     = main_d.c[3];
  assign corr.corr_b_y     = main_d.c[4];
  assign corr.corr_b_z     = main_d.c[5];
  assign corr.out_point_a  = xpbd_pkg::FIELD_IDX_W'(main_d.idx[IDX_W-1:KEEP+xpbd_pkg::GEO_W]);
  assign corr.out_point_b  = xpbd_pkg::FIELD_IDX_W'(main_d.idx[KEEP+xpbd_pkg::GEO_W-1:
                                                                xpbd_pkg::GEO_W]);
  assign corr.out_geometry = main_d.idx[xpbd_pkg::GEO_W-1:0];
endmodule
